// ----- hdl/mbrtu_pkg.sv -----
// Shared types, constants and the CRC-16 byte update for the RTU frame responder.
package mbrtu_pkg;

  // Modbus CRC-16 seed and reflected polynomial.
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // Function codes the slave recognizes.
  localparam logic [7:0] FC_READ_COILS      = 8'd1;
  localparam logic [7:0] FC_READ_DISCRETE   = 8'd2;
  localparam logic [7:0] FC_READ_HOLDING    = 8'd3;
  localparam logic [7:0] FC_READ_INPUT      = 8'd4;
  localparam logic [7:0] FC_WRITE_COIL      = 8'd5;
  localparam logic [7:0] FC_WRITE_REGISTER  = 8'd6;
  localparam logic [7:0] FC_WRITE_COILS     = 8'd15;
  localparam logic [7:0] FC_WRITE_REGISTERS = 8'd16;

  // Exception reply codes and the flag set in the echoed function code.
  localparam logic [7:0] EXC_ILLEGAL_FUNCTION = 8'h01;
  localparam logic [7:0] EXC_ILLEGAL_ADDRESS  = 8'h02;
  localparam logic [7:0] EXC_BAD_CRC          = 8'h04;
  localparam logic [7:0] EXC_FLAG             = 8'h80;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_SLAVE_ADDRESS  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REGISTER_LIMIT = 1'd1;

  // Number of header bytes kept per frame.
  localparam int unsigned HDR_BYTES = 6;

  // Kind of reply a finished frame calls for.
  typedef enum logic [1:0] {
    JOB_NONE,
    JOB_EXCEPTION,
    JOB_ECHO
  } job_kind_t;

  // One reply job handed from the front end to the transmitter.
  typedef struct packed {
    job_kind_t                     kind;
    logic [7:0]                    code;
    logic [HDR_BYTES-1:0][7:0]     hdr;
  } job_t;

  // One byte of the reflected CRC-16 update.
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ----- hdl/mbrtu_front.sv -----
// Front end: takes frame bytes, tracks count, CRC and header, classifies the frame at its end.
module mbrtu_front
  import mbrtu_pkg::*;
#(
  parameter int unsigned MAX_FRAME = 256
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_addr,
  input  logic [15:0]          cfg_wdata,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [7:0]           in_tdata,
  input  logic                 in_tlast,
  input  logic                 q_full,
  output logic                 q_push,
  output job_t                 q_job
);

  localparam int unsigned CW = $clog2(MAX_FRAME + 1);

  logic [7:0]                slave_addr_r;
  logic [15:0]               reg_limit_r;
  logic [CW-1:0]             count_r, count_nxt;
  logic [15:0]               crc_r, crc_nxt;
  logic [7:0]                tail0_r, tail0_nxt, tail1_r, tail1_nxt;
  logic [HDR_BYTES-1:0][7:0] hdr_r, hdr_nxt;
  logic                      accept;
  logic                      take;
  logic                      fc_ok;
  logic [15:0]               start_reg;
  logic [15:0]               rcv_crc;
  job_kind_t                 kind;
  logic [7:0]                code;

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;
  assign take      = count_r < CW'(MAX_FRAME);

  // Per-byte update of the frame trackers, as seen after this transfer.
  always_comb begin
    count_nxt = count_r;
    crc_nxt   = crc_r;
    tail0_nxt = tail0_r;
    tail1_nxt = tail1_r;
    hdr_nxt   = hdr_r;
    if (take) begin
      if (count_r >= CW'(2)) begin
        crc_nxt = crc_feed(crc_r, tail0_r);
      end
      tail0_nxt = tail1_r;
      tail1_nxt = in_tdata;
      for (int k = 0; k < HDR_BYTES; k++) begin
        if (count_r == CW'(k)) begin
          hdr_nxt[k] = in_tdata;
        end
      end
      count_nxt = count_r + CW'(1);
    end
  end

  // Frame checks in priority order.
  always_comb begin
    unique case (hdr_nxt[1])
      FC_READ_COILS, FC_READ_DISCRETE, FC_READ_HOLDING, FC_READ_INPUT,
      FC_WRITE_COIL, FC_WRITE_REGISTER, FC_WRITE_COILS, FC_WRITE_REGISTERS: fc_ok = 1'b1;
      default: fc_ok = 1'b0;
    endcase
  end

  assign start_reg = {hdr_nxt[2], hdr_nxt[3]};
  assign rcv_crc   = {tail1_nxt, tail0_nxt};

  always_comb begin
    kind = JOB_NONE;
    code = EXC_ILLEGAL_FUNCTION;
    priority if (count_nxt < CW'(4)) begin
      kind = JOB_NONE;
    end else if (hdr_nxt[0] != slave_addr_r) begin
      kind = JOB_NONE;
    end else if (!fc_ok) begin
      kind = JOB_EXCEPTION;
      code = EXC_ILLEGAL_FUNCTION;
    end else if (start_reg >= reg_limit_r) begin
      kind = JOB_EXCEPTION;
      code = EXC_ILLEGAL_ADDRESS;
    end else if (rcv_crc != crc_nxt) begin
      kind = JOB_EXCEPTION;
      code = EXC_BAD_CRC;
    end else if (hdr_nxt[1] == FC_WRITE_REGISTER) begin
      kind = JOB_ECHO;
    end else begin
      kind = JOB_NONE;
    end
  end

  assign q_push     = accept && in_tlast && (kind != JOB_NONE);
  assign q_job.kind = kind;
  assign q_job.code = code;
  assign q_job.hdr  = hdr_nxt;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slave_addr_r <= 8'd3;
      reg_limit_r  <= 16'd1000;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_SLAVE_ADDRESS:  slave_addr_r <= cfg_wdata[7:0];
        CFG_REGISTER_LIMIT: reg_limit_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Frame state; everything returns to its reset value at frame end.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      crc_r   <= CRC_INIT;
      tail0_r <= '0;
      tail1_r <= '0;
      hdr_r   <= '0;
    end else if (accept) begin
      if (in_tlast) begin
        count_r <= '0;
        crc_r   <= CRC_INIT;
        tail0_r <= '0;
        tail1_r <= '0;
        hdr_r   <= '0;
      end else begin
        count_r <= count_nxt;
        crc_r   <= crc_nxt;
        tail0_r <= tail0_nxt;
        tail1_r <= tail1_nxt;
        hdr_r   <= hdr_nxt;
      end
    end
  end

endmodule

// ----- hdl/mbrtu_queue.sv -----
// Two-entry job queue between the frame front end and the reply transmitter.
module mbrtu_queue
  import mbrtu_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output logic empty,
  output job_t pop_job
);

  localparam int unsigned DEPTH = 2;
  localparam int unsigned PW    = $clog2(DEPTH);

  job_t          mem [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [PW:0]   fill_r;
  logic          do_push, do_pop;

  assign full    = fill_r == (PW+1)'(DEPTH);
  assign empty   = fill_r == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_job = mem[rd_ptr_r];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_job;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + PW'(1);
      end
      unique case ({do_push, do_pop})
        2'b10:   fill_r <= fill_r + (PW+1)'(1);
        2'b01:   fill_r <= fill_r - (PW+1)'(1);
        default: fill_r <= fill_r;
      endcase
    end
  end

endmodule

// ----- hdl/mbrtu_back.sv -----
// Reply transmitter: plays out exception and echo replies one byte per transfer.
module mbrtu_back
  import mbrtu_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_empty,
  input  job_t       q_job,
  output logic       q_pop,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,
  output logic       out_tlast
);

  logic        busy_r;
  job_t        job_r;
  logic [2:0]  idx_r;
  logic [15:0] crc_r;
  logic        out_valid_r;
  logic [7:0]  out_data_r;
  logic        out_last_r;
  logic        emit;
  logic [7:0]  byte_sel;
  logic        last_sel;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  assign q_pop = !busy_r && !q_empty;
  assign emit  = busy_r && (!out_valid_r || out_tready);

  // Select the next reply byte for the current job.
  always_comb begin
    byte_sel = job_r.hdr[0];
    last_sel = 1'b0;
    if (job_r.kind == JOB_EXCEPTION) begin
      unique case (idx_r)
        3'd0:    byte_sel = job_r.hdr[0];
        3'd1:    byte_sel = job_r.hdr[1] | EXC_FLAG;
        default: begin
          byte_sel = job_r.code;
          last_sel = 1'b1;
        end
      endcase
    end else begin
      unique case (idx_r)
        3'd6:    byte_sel = crc_r[7:0];
        3'd7:    begin
          byte_sel = crc_r[15:8];
          last_sel = 1'b1;
        end
        default: byte_sel = job_r.hdr[idx_r];
      endcase
    end
  end

  // Job sequencing and the echo CRC, fed as header bytes go out.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
      crc_r  <= CRC_INIT;
    end else if (q_pop) begin
      busy_r <= 1'b1;
      idx_r  <= '0;
      crc_r  <= CRC_INIT;
    end else if (emit) begin
      idx_r <= idx_r + 3'd1;
      if (idx_r < 3'd6) begin
        crc_r <= crc_feed(crc_r, byte_sel);
      end
      if (last_sel) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      job_r <= q_job;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data_r <= byte_sel;
      out_last_r <= last_sel;
    end
  end

endmodule

// ----- hdl/modbus_rtu_slave_frame_responder_unit.sv -----
// Top level of the Modbus RTU slave frame responder.
// Frame bytes stream in on the in_ channel, one byte per cycle, with tlast on the
// last byte of a frame; the only stall comes when two finished replies already
// wait in the job queue. At frame end the front end checks length, slave address,
// function code, start register and CRC in the same cycle and queues a reply job;
// the transmitter then sends an exception reply (address, code with bit 7 set,
// exception code) or, for write single register, the six header bytes and their
// CRC low byte first, one byte per cycle on out_ while out_tready is high. Frames
// shorter than four bytes, frames for another address and other valid codes give no
// reply. Bytes beyond MAX_FRAME are ignored, though their tlast still ends the frame.
module modbus_rtu_slave_frame_responder_unit
  import mbrtu_pkg::*;
#(
  parameter int unsigned MAX_FRAME = 256
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_addr,
  input  logic [15:0]          cfg_wdata,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [7:0]           in_tdata,   // [7:0] rx_byte
  input  logic                 in_tlast,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [7:0]           out_tdata,  // [7:0] tx_byte
  output logic                 out_tlast
);

  logic q_full, q_push, q_pop, q_empty;
  job_t push_job, pop_job;

  mbrtu_front #(
    .MAX_FRAME (MAX_FRAME)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_job     (push_job)
  );

  mbrtu_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .pop_job  (pop_job)
  );

  mbrtu_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_job      (pop_job),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

// ----- tb/sv/tb_modbus_rtu_slave_frame_responder_unit.sv -----
// Self-checking testbench for the Modbus RTU slave frame responder.
module tb_modbus_rtu_slave_frame_responder_unit;
  import mbrtu_pkg::*;

  localparam int unsigned FRAME_CAP = 256;
  localparam int STALL_LIMIT = 4000;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES = 16;
  localparam logic [7:0] VALID_FC [8] = '{FC_READ_COILS, FC_READ_DISCRETE, FC_READ_HOLDING,
                                          FC_READ_INPUT, FC_WRITE_COIL, FC_WRITE_REGISTER,
                                          FC_WRITE_COILS, FC_WRITE_REGISTERS};

  // One byte on either stream together with its end-of-frame marker.
  typedef struct packed {
    logic [7:0] value;
    logic       is_last;
  } beat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_addr = '0;
  logic [15:0] cfg_wdata = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [7:0] in_tdata = '0;
  logic in_tlast = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic out_tlast;

  // Stimulus waiting to be sent and reply bytes still owed by the block.
  beat_t rx_pending[$];
  beat_t reply_q[$];
  logic [7:0] fbuf[$];
  int items_queued = 0;
  int errors = 0;

  // Predictor copy of the configuration and of the frame state.
  logic [7:0] dev_addr = 8'd3;
  logic [15:0] reg_limit = 16'd1000;
  int unsigned rx_count;
  logic [15:0] rx_crc;
  logic [7:0] tail [2];
  logic [7:0] hdr [HDR_BYTES];

  // Idle pattern control shared by the driver and the monitor.
  bit calm = 1'b0;
  int hold_start = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int rdy_gap = 0;
  int tx_gap = 0;
  int idle_cycles = 0;

  modbus_rtu_slave_frame_responder_unit #(.MAX_FRAME(FRAME_CAP)) uut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast)
  );

  always #4 clk = ~clk;

  // Bit-serial form of the reflected CRC-16, least significant bit first.
  function automatic logic [15:0] crc16_of_byte(input logic [15:0] acc, input logic [7:0] d);
    logic [15:0] a;
    a = acc;
    for (int i = 0; i < 8; i++) begin
      if (a[0] ^ d[i]) begin
        a = {1'b0, a[15:1]} ^ CRC_POLY;
      end else begin
        a = {1'b0, a[15:1]};
      end
    end
    return a;
  endfunction

  function automatic bit known_fc(input logic [7:0] fc);
    foreach (VALID_FC[i]) begin
      if (VALID_FC[i] == fc) return 1'b1;
    end
    return 1'b0;
  endfunction

  // Most gaps are short, a few long, and none at all while calm is set.
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic flag_error(input string msg);
    $display("ERROR at %0t: %s", $realtime, msg);
    errors++;
  endtask

  task automatic owe_reply(input logic [7:0] b, input logic is_last);
    beat_t e;
    e.value = b;
    e.is_last = is_last;
    reply_q.push_back(e);
  endtask

  task automatic clear_rx();
    rx_count = 0;
    rx_crc = CRC_INIT;
    tail[0] = '0;
    tail[1] = '0;
    foreach (hdr[k]) hdr[k] = '0;
  endtask

  task automatic reply_exception(input logic [7:0] exc);
    owe_reply(hdr[0], 1'b0);
    owe_reply(hdr[1] | EXC_FLAG, 1'b0);
    owe_reply(exc, 1'b1);
  endtask

  // Frame-end decision: length, address, code, start register, CRC, then echo.
  task automatic judge_frame();
    logic [7:0] fc;
    logic [15:0] start;
    logic [15:0] echo_crc;
    if (rx_count < 4) return;
    if (hdr[0] != dev_addr) return;
    fc = hdr[1];
    if (!known_fc(fc)) begin
      reply_exception(EXC_ILLEGAL_FUNCTION);
      return;
    end
    start = {hdr[2], hdr[3]};
    if (start >= reg_limit) begin
      reply_exception(EXC_ILLEGAL_ADDRESS);
      return;
    end
    if ({tail[1], tail[0]} != rx_crc) begin
      reply_exception(EXC_BAD_CRC);
      return;
    end
    if (fc != FC_WRITE_REGISTER) return;
    echo_crc = CRC_INIT;
    for (int k = 0; k < HDR_BYTES; k++) begin
      echo_crc = crc16_of_byte(echo_crc, hdr[k]);
      owe_reply(hdr[k], 1'b0);
    end
    owe_reply(echo_crc[7:0], 1'b0);
    owe_reply(echo_crc[15:8], 1'b1);
  endtask

  // Advance the predicted frame state by one accepted byte.
  task automatic track_rx(input logic [7:0] b, input logic fend);
    if (rx_count < FRAME_CAP) begin
      if (rx_count >= 2) rx_crc = crc16_of_byte(rx_crc, tail[0]);
      tail[0] = tail[1];
      tail[1] = b;
      if (rx_count < HDR_BYTES) hdr[rx_count] = b;
      rx_count++;
    end
    if (fend) begin
      judge_frame();
      clear_rx();
    end
  endtask

  // Append the CRC of the bytes built so far, low byte first; a bad one is corrupted.
  task automatic seal_crc(input bit good);
    logic [15:0] c;
    c = CRC_INIT;
    foreach (fbuf[i]) c = crc16_of_byte(c, fbuf[i]);
    if (!good) c = c ^ 16'($urandom_range(1, 65535));
    fbuf.push_back(c[7:0]);
    fbuf.push_back(c[15:8]);
  endtask

  // Move the built frame to the driver queue with tlast on its final byte.
  task automatic ship_frame();
    beat_t it;
    foreach (fbuf[i]) begin
      it.value = fbuf[i];
      it.is_last = (i == fbuf.size() - 1);
      rx_pending.push_back(it);
      items_queued++;
    end
    fbuf.delete();
  endtask

  // Mostly well-formed requests with random content, plus noise and runt frames.
  task automatic random_frame(input bit force_echo);
    int r;
    int n;
    logic [7:0] a;
    logic [7:0] fc;
    logic [15:0] start;
    bit good;
    r = force_echo ? 99 : $urandom_range(0, 99);
    a = (force_echo || $urandom_range(0, 99) < 88) ? dev_addr : 8'($urandom);
    if (r < 10) begin
      n = $urandom_range(1, 12);
      repeat (n) fbuf.push_back(8'($urandom));
    end else if (r < 16) begin
      fbuf.push_back(a);
      repeat ($urandom_range(0, 2)) fbuf.push_back(8'($urandom));
    end else begin
      r = force_echo ? 0 : $urandom_range(0, 99);
      if (r < 45) fc = FC_WRITE_REGISTER;
      else if (r < 82) fc = VALID_FC[$urandom_range(0, 7)];
      else fc = 8'($urandom);
      if (reg_limit != 0 && (force_echo || $urandom_range(0, 99) < 85)) begin
        start = 16'($urandom_range(0, int'(reg_limit) - 1));
      end else begin
        start = 16'($urandom_range(int'(reg_limit), 65535));
      end
      fbuf.push_back(a);
      fbuf.push_back(fc);
      // Occasionally cut the header short so bytes four and five go missing.
      n = force_echo ? 9 : $urandom_range(0, 9);
      if (n >= 1) fbuf.push_back(start[15:8]);
      if (n >= 2) begin
        fbuf.push_back(start[7:0]);
        n = (fc == FC_WRITE_REGISTER) ? 2 : $urandom_range(0, 6);
        repeat (n) fbuf.push_back(8'($urandom));
      end
      good = force_echo || $urandom_range(0, 99) < 88;
      seal_crc(good);
    end
    ship_frame();
  endtask

  task automatic random_run(input int n_items);
    int target;
    target = items_queued + n_items;
    while (items_queued < target) random_frame(1'b0);
  endtask

  // Wait until every byte is sent and every reply byte has come, then let the block settle.
  task automatic quiesce();
    do @(negedge clk); while (rx_pending.size() != 0 || in_tvalid || reply_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    if (idx == CFG_SLAVE_ADDRESS) dev_addr = val[7:0];
    else reg_limit = val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Input driver: offer queued bytes, inserting random gaps between transfers.
  always @(posedge clk) begin
    beat_t it;
    if (rst_n) begin
      if (in_tvalid && in_tready) track_rx(in_tdata, in_tlast);
      if (!in_tvalid || in_tready) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_tvalid <= 1'b0;
        end else if (rx_pending.size() != 0) begin
          it = rx_pending.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= it.value;
          in_tlast <= it.is_last;
          tx_gap = pick_gap();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Reply monitor: check each transfer against the oldest owed byte and pace tready.
  always @(posedge clk) begin
    beat_t e;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (reply_q.size() == 0) begin
          flag_error($sformatf("unexpected reply byte %02h last %0b", out_tdata, out_tlast));
        end else begin
          e = reply_q.pop_front();
          if (out_tdata !== e.value)
            flag_error($sformatf("tx_byte %02h, want %02h", out_tdata, e.value));
          if (out_tlast !== e.is_last)
            flag_error($sformatf("tx_last %0b, want %0b", out_tlast, e.is_last));
        end
      end
      if (hold_seen != hold_start) begin
        hold_seen = hold_start;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (rdy_gap > 0) begin
        rdy_gap--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        rdy_gap = pick_gap();
      end
    end
  end

  // Watchdog: end the run if no transfer happens on either side for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
          $display("Simulation FAILED");
          $finish;
        end
      end
    end
  end

  // Stimulus sequence: directed frames on reset settings, then random and directed phases at other settings.
  initial begin
    clear_rx();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: echo of write single register.
    fbuf = '{dev_addr, FC_WRITE_REGISTER, 8'h00, 8'h10, 8'hAB, 8'hCD};
    seal_crc(1'b1);
    ship_frame();
    // Unknown function code at the top of the byte range.
    fbuf = '{dev_addr, 8'hFF};
    seal_crc(1'b1);
    ship_frame();
    // Start register exactly at the limit.
    fbuf = '{dev_addr, FC_READ_HOLDING, 8'h03, 8'hE8};
    ship_frame();
    // CRC mismatch on an in-range request.
    fbuf = '{dev_addr, FC_READ_INPUT, 8'h00, 8'h00};
    ship_frame();
    // Runt frame and a frame for another slave.
    fbuf = '{dev_addr, FC_WRITE_REGISTER};
    ship_frame();
    fbuf = '{8'h04, FC_WRITE_REGISTER};
    seal_crc(1'b1);
    ship_frame();
    quiesce();

    // Low extremes: address zero, every start register out of range.
    set_reg(CFG_SLAVE_ADDRESS, 16'h0000);
    set_reg(CFG_REGISTER_LIMIT, 16'h0000);
    random_run(10);
    quiesce();

    // High extremes, a header missing bytes four and five, and an overlong frame.
    set_reg(CFG_SLAVE_ADDRESS, 16'h00FF);
    set_reg(CFG_REGISTER_LIMIT, 16'hFFFF);
    fbuf = '{dev_addr, FC_WRITE_REGISTER};
    seal_crc(1'b1);
    ship_frame();
    fbuf = '{dev_addr, FC_WRITE_REGISTER, 8'h12};
    seal_crc(1'b1);
    ship_frame();
    fbuf = '{dev_addr, FC_WRITE_REGISTER};
    while (fbuf.size() < FRAME_CAP - 2) fbuf.push_back(8'($urandom));
    seal_crc(1'b1);
    repeat (2) fbuf.push_back(8'($urandom));
    ship_frame();
    quiesce();

    // Back-pressure: receiver holds off while echo requests pile up, then drains
    // with no idling on either side.
    calm = 1'b1;
    set_reg(CFG_SLAVE_ADDRESS, 16'($urandom_range(0, 255)));
    set_reg(CFG_REGISTER_LIMIT, 16'($urandom_range(1, 65535)));
    hold_start++;
    repeat (4) random_frame(1'b1);
    quiesce();
    calm = 1'b0;

    if (errors == 0 && reply_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/mbrtu_pkg.sv
hdl/mbrtu_front.sv
hdl/mbrtu_queue.sv
hdl/mbrtu_back.sv
hdl/modbus_rtu_slave_frame_responder_unit.sv
tb/sv/tb_modbus_rtu_slave_frame_responder_unit.sv
